FILE: hdl/tcrw_pkg.sv
// Shared types, constants and time helpers for the touch controller recovery watchdog.
// No dependencies; the design files use it by scoped names and the bench imports it.
package tcrw_pkg;

  localparam int TIME_BITS       = 32;
  localparam int STAT_BITS       = 32;
  localparam int RUNG_STEPS      = 4;
  localparam int FIRST_HARD_STEP = 2;
  localparam int RUNG_BITS       = (RUNG_STEPS > 1) ? $clog2(RUNG_STEPS) : 1;
  localparam int CFG_COUNT       = 8;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;
  localparam int SUSPECT_MAX     = 15;

  localparam logic [TIME_BITS-1:0] PROBE_DEADLINE_RESET = TIME_BITS'(3000);

  typedef enum logic [2:0] {
    M_HEALTHY  = 3'd0,
    M_SUSPECT  = 3'd1,
    M_WAKEBOOT = 3'd2,
    M_SOFTBOOT = 3'd3,
    M_RSTLOW   = 3'd4,
    M_RSTHIGH  = 3'd5,
    M_HARDBOOT = 3'd6,
    M_BACKOFF  = 3'd7
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PROBE_INTERVAL = 3'd0,
    CFG_AWAKE_WINDOW   = 3'd1,
    CFG_SUSPECT_LIMIT  = 3'd2,
    CFG_SUSPECT_SPACE  = 3'd3,
    CFG_BOOT_WAIT      = 3'd4,
    CFG_RESET_LOW      = 3'd5,
    CFG_RESET_SETTLE   = 3'd6,
    CFG_REBOOT_AFTER   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] probe_interval_ms;
    logic [15:0] awake_span_ms;
    logic [3:0]  suspect_probe_limit;
    logic [15:0] suspect_gap_ms;
    logic [15:0] boot_hold_ms;
    logic [15:0] reset_low_ms;
    logic [15:0] reset_settle_ms;
    logic [31:0] reboot_bound_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 saw_touch;
    logic                 may_probe;
    logic                 probe_ack;
  } item_t;

  typedef struct packed {
    mode_e                mode;
    logic                 previous_touch;
    logic                 release_probe_pending;
    logic [TIME_BITS-1:0] last_touch_time;
    logic [3:0]           suspect_failures;
    logic [TIME_BITS-1:0] action_deadline;
    logic [RUNG_BITS-1:0] rung_position;
    logic [TIME_BITS-1:0] probe_deadline;
    logic [TIME_BITS-1:0] wedge_start_time;
    logic                 episode_valid;
    logic                 reboot_flag;
    logic                 reset_line_low;
    logic [STAT_BITS-1:0] wedges_total;
    logic [STAT_BITS-1:0] recoveries_total;
    logic [STAT_BITS-1:0] wakes_total;
    logic [STAT_BITS-1:0] last_outage;
    logic [STAT_BITS-1:0] longest_outage;
  } state_t;

  typedef struct packed {
    logic        probe_issued;
    logic        driver_reinit;
    logic        reset_held_low;
    logic        reboot_recommended;
    logic [2:0]  watch_state;
    logic [1:0]  ladder_rung;
    logic [31:0] last_outage_ms;
    logic [31:0] max_outage_ms;
    logic [31:0] wedge_count;
    logic [31:0] recovery_count;
    logic [31:0] wake_count;
  } result_t;

  // Backoff delay per ladder rung; rungs past the end reuse the last delay.
  function automatic logic [TIME_BITS-1:0] rung_delay(logic [RUNG_BITS-1:0] rung);
    logic [TIME_BITS-1:0] dly;
    if (int'(rung) == 0) begin
      dly = TIME_BITS'(5000);
    end else if (int'(rung) == 1) begin
      dly = TIME_BITS'(15000);
    end else if (int'(rung) == 2) begin
      dly = TIME_BITS'(40000);
    end else begin
      dly = TIME_BITS'(120000);
    end
    return dly;
  endfunction

  // A deadline is reached once now is at it or past it by less than half the time range.
  function automatic logic reached(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] dl);
    logic [TIME_BITS-1:0] diff;
    diff = now - dl;
    return ~diff[TIME_BITS-1];
  endfunction

endpackage

FILE: hdl/tcrw_if.sv
// Valid/ready channel interfaces for poll items and result items.
// Depends on tcrw_pkg for the time width.
interface tcrw_poll_if;
  logic                           valid;
  logic                           ready;
  logic [tcrw_pkg::TIME_BITS-1:0] now_ms;
  logic                           saw_touch;
  logic                           may_probe;
  logic                           probe_ack;

  modport source (output valid, now_ms, saw_touch, may_probe, probe_ack, input ready);
  modport sink   (input valid, now_ms, saw_touch, may_probe, probe_ack, output ready);
endinterface

interface tcrw_result_if;
  logic        valid;
  logic        ready;
  logic        probe_issued;
  logic        driver_reinit;
  logic        reset_held_low;
  logic        reboot_recommended;
  logic [2:0]  watch_state;
  logic [1:0]  ladder_rung;
  logic [31:0] last_outage_ms;
  logic [31:0] max_outage_ms;
  logic [31:0] wedge_count;
  logic [31:0] recovery_count;
  logic [31:0] wake_count;

  modport source (output valid, probe_issued, driver_reinit, reset_held_low,
                  reboot_recommended, watch_state, ladder_rung, last_outage_ms,
                  max_outage_ms, wedge_count, recovery_count, wake_count,
                  input ready);
  modport sink   (input valid, probe_issued, driver_reinit, reset_held_low,
                  reboot_recommended, watch_state, ladder_rung, last_outage_ms,
                  max_outage_ms, wedge_count, recovery_count, wake_count,
                  output ready);
endinterface

FILE: hdl/tcrw_cfg.sv
// Configuration register bank of the watchdog, written through a plain write port.
// Depends on tcrw_pkg for the register index codes and the cfg_t struct.
module tcrw_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcrw_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [tcrw_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output tcrw_pkg::cfg_t                      cfg_o
);

  tcrw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcrw_pkg::CFG_PROBE_INTERVAL: cfg_d.probe_interval_ms   = cfg_wdata_i[31:0];
        tcrw_pkg::CFG_AWAKE_WINDOW:   cfg_d.awake_span_ms       = cfg_wdata_i[15:0];
        tcrw_pkg::CFG_SUSPECT_LIMIT:  cfg_d.suspect_probe_limit = cfg_wdata_i[3:0];
        tcrw_pkg::CFG_SUSPECT_SPACE:  cfg_d.suspect_gap_ms      = cfg_wdata_i[15:0];
        tcrw_pkg::CFG_BOOT_WAIT:      cfg_d.boot_hold_ms        = cfg_wdata_i[15:0];
        tcrw_pkg::CFG_RESET_LOW:      cfg_d.reset_low_ms        = cfg_wdata_i[15:0];
        tcrw_pkg::CFG_RESET_SETTLE:   cfg_d.reset_settle_ms     = cfg_wdata_i[15:0];
        tcrw_pkg::CFG_REBOOT_AFTER:   cfg_d.reboot_bound_ms     = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_interval_ms   <= 32'd10000;
      cfg_q.awake_span_ms       <= 16'd1200;
      cfg_q.suspect_probe_limit <= 4'd3;
      cfg_q.suspect_gap_ms      <= 16'd150;
      cfg_q.boot_hold_ms        <= 16'd450;
      cfg_q.reset_low_ms        <= 16'd250;
      cfg_q.reset_settle_ms     <= 16'd650;
      cfg_q.reboot_bound_ms     <= 32'd90000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/tcrw_step.sv
// Combinational step of the watchdog: next state and result for one poll item.
// Depends on tcrw_pkg for the state, item, result and configuration types.
module tcrw_step (
  input  tcrw_pkg::cfg_t    cfg_i,
  input  tcrw_pkg::state_t  st_i,
  input  tcrw_pkg::item_t   item_i,
  output tcrw_pkg::state_t  st_o,
  output tcrw_pkg::result_t res_o
);

  localparam int TW = tcrw_pkg::TIME_BITS;
  localparam logic [tcrw_pkg::RUNG_BITS-1:0] RungLast =
    tcrw_pkg::RUNG_BITS'(tcrw_pkg::RUNG_STEPS - 1);

  tcrw_pkg::state_t s;
  logic             rel_edge;
  logic             probed;
  logic             reinit;
  logic             due;
  logic [TW-1:0]    now;
  logic [TW-1:0]    outage;
  logic [TW-1:0]    since_wedge;
  logic [TW-1:0]    since_touch;

  always_comb begin
    s      = st_i;
    now    = item_i.now_ms;
    probed = 1'b0;
    reinit = 1'b0;

    // A touch read refreshes the awake time and cancels a suspicion at once.
    if (item_i.saw_touch) begin
      s.last_touch_time = now;
      if (s.mode == tcrw_pkg::M_SUSPECT) begin
        s.mode             = tcrw_pkg::M_HEALTHY;
        s.suspect_failures = 4'd0;
      end
    end
    rel_edge         = st_i.previous_touch & ~item_i.saw_touch;
    s.previous_touch = item_i.saw_touch;

    since_wedge = now - s.wedge_start_time;
    if (s.episode_valid && !s.reboot_flag && (since_wedge > cfg_i.reboot_bound_ms)) begin
      s.reboot_flag = 1'b1;
    end

    since_touch = now - s.last_touch_time;
    outage      = since_wedge;
    due         = item_i.may_probe & tcrw_pkg::reached(now, s.action_deadline);

    case (s.mode)
      tcrw_pkg::M_HEALTHY: begin
        if (rel_edge) begin
          s.release_probe_pending = 1'b1;
        end
        if (s.release_probe_pending && item_i.may_probe) begin
          s.release_probe_pending = 1'b0;
          if (since_touch <= TW'(cfg_i.awake_span_ms)) begin
            probed = 1'b1;
            if (!item_i.probe_ack) begin
              s.suspect_failures = 4'd1;
              s.action_deadline  = now + TW'(cfg_i.suspect_gap_ms);
              s.mode             = tcrw_pkg::M_SUSPECT;
            end
          end
        end else if ((cfg_i.probe_interval_ms != '0) && item_i.may_probe &&
                     tcrw_pkg::reached(now, s.probe_deadline)) begin
          s.probe_deadline = now + cfg_i.probe_interval_ms;
          probed           = 1'b1;
          if (!item_i.probe_ack) begin
            reinit            = 1'b1;
            s.mode            = tcrw_pkg::M_WAKEBOOT;
            s.action_deadline = now + TW'(cfg_i.boot_hold_ms);
          end
        end
      end
      tcrw_pkg::M_SUSPECT: begin
        if (due) begin
          probed = 1'b1;
          if (item_i.probe_ack) begin
            s.suspect_failures = 4'd0;
            s.mode             = tcrw_pkg::M_HEALTHY;
          end else begin
            if (s.suspect_failures != 4'(tcrw_pkg::SUSPECT_MAX)) begin
              s.suspect_failures = s.suspect_failures + 4'd1;
            end
            if (s.suspect_failures >= cfg_i.suspect_probe_limit) begin
              s.wedges_total     = s.wedges_total + tcrw_pkg::STAT_BITS'(1);
              s.wedge_start_time = now;
              s.episode_valid    = 1'b1;
              s.rung_position    = '0;
              s.mode             = tcrw_pkg::M_BACKOFF;
              s.action_deadline  = now + tcrw_pkg::rung_delay('0);
            end else begin
              s.action_deadline = now + TW'(cfg_i.suspect_gap_ms);
            end
          end
        end
      end
      tcrw_pkg::M_WAKEBOOT: begin
        if (due) begin
          probed = 1'b1;
          if (item_i.probe_ack) begin
            s.wakes_total = s.wakes_total + tcrw_pkg::STAT_BITS'(1);
            s.mode        = tcrw_pkg::M_HEALTHY;
          end else begin
            s.wedges_total     = s.wedges_total + tcrw_pkg::STAT_BITS'(1);
            s.wedge_start_time = now;
            s.episode_valid    = 1'b1;
            s.rung_position    = '0;
            s.mode             = tcrw_pkg::M_BACKOFF;
            s.action_deadline  = now + tcrw_pkg::rung_delay('0);
          end
        end
      end
      tcrw_pkg::M_SOFTBOOT, tcrw_pkg::M_HARDBOOT: begin
        if (due) begin
          probed = 1'b1;
          if (item_i.probe_ack) begin
            s.recoveries_total = s.recoveries_total + tcrw_pkg::STAT_BITS'(1);
            s.last_outage      = outage;
            if (outage > s.longest_outage) begin
              s.longest_outage = outage;
            end
            s.episode_valid    = 1'b0;
            s.wedge_start_time = '0;
            s.reboot_flag      = 1'b0;
            s.rung_position    = '0;
            s.mode             = tcrw_pkg::M_HEALTHY;
          end else begin
            if (s.rung_position != RungLast) begin
              s.rung_position = s.rung_position + tcrw_pkg::RUNG_BITS'(1);
            end
            s.mode            = tcrw_pkg::M_BACKOFF;
            s.action_deadline = now + tcrw_pkg::rung_delay(s.rung_position);
          end
        end
      end
      tcrw_pkg::M_RSTLOW: begin
        // Releasing the reset line needs no bus.
        if (tcrw_pkg::reached(now, s.action_deadline)) begin
          s.reset_line_low  = 1'b0;
          s.mode            = tcrw_pkg::M_RSTHIGH;
          s.action_deadline = now + TW'(cfg_i.reset_settle_ms);
        end
      end
      tcrw_pkg::M_RSTHIGH: begin
        if (due) begin
          reinit            = 1'b1;
          s.mode            = tcrw_pkg::M_HARDBOOT;
          s.action_deadline = now + TW'(cfg_i.boot_hold_ms);
        end
      end
      default: begin
        if (due) begin
          if (int'(s.rung_position) >= tcrw_pkg::FIRST_HARD_STEP) begin
            s.reset_line_low  = 1'b1;
            s.mode            = tcrw_pkg::M_RSTLOW;
            s.action_deadline = now + TW'(cfg_i.reset_low_ms);
          end else begin
            reinit            = 1'b1;
            s.mode            = tcrw_pkg::M_SOFTBOOT;
            s.action_deadline = now + TW'(cfg_i.boot_hold_ms);
          end
        end
      end
    endcase
  end

  assign st_o = s;

  always_comb begin
    res_o.probe_issued       = probed;
    res_o.driver_reinit      = reinit;
    res_o.reset_held_low     = s.reset_line_low;
    res_o.reboot_recommended = s.reboot_flag;
    res_o.watch_state        = s.mode;
    res_o.ladder_rung        = 2'(s.rung_position);
    res_o.last_outage_ms     = s.last_outage[31:0];
    res_o.max_outage_ms      = s.longest_outage[31:0];
    res_o.wedge_count        = s.wedges_total[31:0];
    res_o.recovery_count     = s.recoveries_total[31:0];
    res_o.wake_count         = s.wakes_total[31:0];
  end

endmodule

FILE: hdl/touch_controller_recovery_watchdog.sv
// A poll item accepted into the input register is stepped into the result register
// once it is free, and the result is then offered on the result port.
// Throughput: one item per cycle while results are taken; the state and result
// registers are written together by each step, from a combinational next state.
// Reset (asynchronous, active low) restores the configuration to its default values,
// clears the watchdog state and counters and empties both stages at once.
module touch_controller_recovery_watchdog (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcrw_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tcrw_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  tcrw_poll_if.sink                          poll_i,
  tcrw_result_if.source                      result_o
);

  tcrw_pkg::cfg_t    cfg;
  tcrw_pkg::state_t  state_q, state_d;
  tcrw_pkg::item_t   item_q;
  tcrw_pkg::result_t res_d, res_q;
  logic              item_vld_q;
  logic              res_vld_q;
  logic              res_free;
  logic              step_fire;
  logic              poll_fire;

  tcrw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcrw_step u_step (
    .cfg_i  (cfg),
    .st_i   (state_q),
    .item_i (item_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  assign res_free     = ~res_vld_q | result_o.ready;
  assign step_fire    = item_vld_q & res_free;
  assign poll_i.ready = ~item_vld_q | res_free;
  assign poll_fire    = poll_i.valid & poll_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (poll_fire) begin
        item_vld_q <= 1'b1;
      end else if (step_fire) begin
        item_vld_q <= 1'b0;
      end
      if (step_fire) begin
        res_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode                  <= tcrw_pkg::M_HEALTHY;
      state_q.previous_touch        <= 1'b0;
      state_q.release_probe_pending <= 1'b0;
      state_q.last_touch_time       <= '0;
      state_q.suspect_failures      <= '0;
      state_q.action_deadline       <= '0;
      state_q.rung_position         <= '0;
      state_q.probe_deadline        <= tcrw_pkg::PROBE_DEADLINE_RESET;
      state_q.wedge_start_time      <= '0;
      state_q.episode_valid         <= 1'b0;
      state_q.reboot_flag           <= 1'b0;
      state_q.reset_line_low        <= 1'b0;
      state_q.wedges_total          <= '0;
      state_q.recoveries_total      <= '0;
      state_q.wakes_total           <= '0;
      state_q.last_outage           <= '0;
      state_q.longest_outage        <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_fire) begin
      item_q.now_ms    <= poll_i.now_ms;
      item_q.saw_touch <= poll_i.saw_touch;
      item_q.may_probe <= poll_i.may_probe;
      item_q.probe_ack <= poll_i.probe_ack;
    end
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid              = res_vld_q;
  assign result_o.probe_issued       = res_q.probe_issued;
  assign result_o.driver_reinit      = res_q.driver_reinit;
  assign result_o.reset_held_low     = res_q.reset_held_low;
  assign result_o.reboot_recommended = res_q.reboot_recommended;
  assign result_o.watch_state        = res_q.watch_state;
  assign result_o.ladder_rung        = res_q.ladder_rung;
  assign result_o.last_outage_ms     = res_q.last_outage_ms;
  assign result_o.max_outage_ms      = res_q.max_outage_ms;
  assign result_o.wedge_count        = res_q.wedge_count;
  assign result_o.recovery_count     = res_q.recovery_count;
  assign result_o.wake_count         = res_q.wake_count;

endmodule

FILE: hdl/tcrw_checker.sv
// Port-level checks of the watchdog results, attached to the top level by bind.
// Depends on tcrw_pkg for the mode codes and on the top level's channel ports.
module tcrw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       probe_issued_i,
  input logic       driver_reinit_i,
  input logic       reset_held_low_i,
  input logic       reboot_recommended_i,
  input logic [2:0] watch_state_i
);

  // The reset line is driven low exactly while the ladder waits in the reset-low state.
  a_reset_line_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (reset_held_low_i == (watch_state_i == tcrw_pkg::M_RSTLOW)))
    else $error("reset line level disagrees with watch state");

  // A re-init always leaves the watchdog waiting in one of the boot states.
  a_reinit_enters_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && driver_reinit_i) |->
      (watch_state_i == tcrw_pkg::M_WAKEBOOT || watch_state_i == tcrw_pkg::M_SOFTBOOT ||
       watch_state_i == tcrw_pkg::M_HARDBOOT))
    else $error("re-init without a boot state");

  // Probe and re-init together only come from a failed standing probe.
  a_probe_reinit_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && probe_issued_i && driver_reinit_i) |->
      (watch_state_i == tcrw_pkg::M_WAKEBOOT))
    else $error("probe with re-init outside wake boot");

  // Reboot advice only stands during a wedge episode, which lives on the ladder.
  a_reboot_on_ladder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && reboot_recommended_i) |->
      (watch_state_i == tcrw_pkg::M_SOFTBOOT || watch_state_i == tcrw_pkg::M_RSTLOW ||
       watch_state_i == tcrw_pkg::M_RSTHIGH || watch_state_i == tcrw_pkg::M_HARDBOOT ||
       watch_state_i == tcrw_pkg::M_BACKOFF))
    else $error("reboot advice outside the recovery ladder");

  // A result that is not taken stays on the port.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(watch_state_i)))
    else $error("stalled result dropped or changed");

endmodule

bind touch_controller_recovery_watchdog tcrw_checker u_tcrw_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .res_valid_i          (result_o.valid),
  .res_ready_i          (result_o.ready),
  .probe_issued_i       (result_o.probe_issued),
  .driver_reinit_i      (result_o.driver_reinit),
  .reset_held_low_i     (result_o.reset_held_low),
  .reboot_recommended_i (result_o.reboot_recommended),
  .watch_state_i        (result_o.watch_state)
);

FILE: bench/tb_top.sv
// Self-checking bench for the touch controller recovery watchdog: drives poll items,
// predicts every result item with a cycle-free model of the watchdog and compares them.
// Depends on tcrw_pkg, the tcrw_poll_if/tcrw_result_if interfaces and the block's RTL.
module tb_top;
  import tcrw_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam bit [31:0] BACKOFF_MS [4] = '{32'd5000, 32'd15000, 32'd40000, 32'd120000};

  typedef struct packed {
    mode_e     mode;
    bit        prev_touch;
    bit        release_pend;
    bit [31:0] touch_time;
    bit [3:0]  fails;
    bit [31:0] deadline;
    bit [1:0]  rung;
    bit [31:0] probe_due;
    bit [31:0] wedge_time;
    bit        in_episode;
    bit        reboot;
    bit        rst_low;
    bit [31:0] n_wedges;
    bit [31:0] n_recoveries;
    bit [31:0] n_wakes;
    bit [31:0] outage_last;
    bit [31:0] outage_max;
  } watchdog_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  tcrw_poll_if   poll_if ();
  tcrw_result_if result_if ();

  touch_controller_recovery_watchdog DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .poll_i      (poll_if),
    .result_o    (result_if)
  );

  watchdog_t wd;
  cfg_t      wd_cfg;
  item_t     poll_backlog [$];
  result_t   report_fifo [$];
  int        bad_fields;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        holds_wanted;
  int        holds_served;
  int        hold_left;
  bit        poll_taken;
  bit [31:0] stim_now;
  bit        stim_touch;
  int        ack_good_pct;
  int        seg_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit due(bit [31:0] now, bit [31:0] mark);
    bit [31:0] d;
    d = now - mark;
    return !d[31];
  endfunction

  function automatic void reset_watchdog();
    wd_cfg.probe_interval_ms   = 32'd10000;
    wd_cfg.awake_span_ms       = 16'd1200;
    wd_cfg.suspect_probe_limit = 4'd3;
    wd_cfg.suspect_gap_ms      = 16'd150;
    wd_cfg.boot_hold_ms        = 16'd450;
    wd_cfg.reset_low_ms        = 16'd250;
    wd_cfg.reset_settle_ms     = 16'd650;
    wd_cfg.reboot_bound_ms     = 32'd90000;
    wd = '0;
    wd.mode = M_HEALTHY;
    wd.probe_due = 32'd3000;
  endfunction

  function automatic void open_wedge(bit [31:0] now);
    wd.n_wedges   = wd.n_wedges + 32'd1;
    wd.wedge_time = now;
    wd.in_episode = 1'b1;
    wd.rung       = '0;
    wd.mode       = M_BACKOFF;
    wd.deadline   = now + BACKOFF_MS[0];
  endfunction

  // One poll through the watchdog; returns the report the block must give for it.
  function automatic result_t advance_watchdog(item_t poll);
    result_t   r;
    bit [31:0] now;
    bit [31:0] since_touch;
    bit [31:0] since_wedge;
    bit        probed;
    bit        reinit;
    bit        released;
    now = poll.now_ms;
    probed = 1'b0;
    reinit = 1'b0;
    if (poll.saw_touch) begin
      wd.touch_time = now;
      if (wd.mode == M_SUSPECT) begin
        wd.mode = M_HEALTHY;
        wd.fails = '0;
      end
    end
    released = wd.prev_touch && !poll.saw_touch;
    wd.prev_touch = poll.saw_touch;
    since_wedge = now - wd.wedge_time;
    if (wd.in_episode && !wd.reboot && since_wedge > wd_cfg.reboot_bound_ms) wd.reboot = 1'b1;

    case (wd.mode)
      M_HEALTHY: begin
        if (released) wd.release_pend = 1'b1;
        if (wd.release_pend && poll.may_probe) begin
          wd.release_pend = 1'b0;
          since_touch = now - wd.touch_time;
          // The release probe only makes sense while the chip is still awake.
          if (since_touch <= 32'(wd_cfg.awake_span_ms)) begin
            probed = 1'b1;
            if (!poll.probe_ack) begin
              wd.fails    = 4'd1;
              wd.deadline = now + 32'(wd_cfg.suspect_gap_ms);
              wd.mode     = M_SUSPECT;
            end
          end
        end else if (wd_cfg.probe_interval_ms != 0 && poll.may_probe &&
                     due(now, wd.probe_due)) begin
          wd.probe_due = now + wd_cfg.probe_interval_ms;
          probed = 1'b1;
          if (!poll.probe_ack) begin
            reinit      = 1'b1;
            wd.mode     = M_WAKEBOOT;
            wd.deadline = now + 32'(wd_cfg.boot_hold_ms);
          end
        end
      end
      M_SUSPECT: begin
        if (poll.may_probe && due(now, wd.deadline)) begin
          probed = 1'b1;
          if (poll.probe_ack) begin
            wd.fails = '0;
            wd.mode  = M_HEALTHY;
          end else begin
            if (wd.fails < 4'd15) wd.fails = wd.fails + 4'd1;
            if (wd.fails >= wd_cfg.suspect_probe_limit) open_wedge(now);
            else wd.deadline = now + 32'(wd_cfg.suspect_gap_ms);
          end
        end
      end
      M_WAKEBOOT: begin
        if (poll.may_probe && due(now, wd.deadline)) begin
          probed = 1'b1;
          if (poll.probe_ack) begin
            wd.n_wakes = wd.n_wakes + 32'd1;
            wd.mode    = M_HEALTHY;
          end else begin
            open_wedge(now);
          end
        end
      end
      M_SOFTBOOT, M_HARDBOOT: begin
        if (poll.may_probe && due(now, wd.deadline)) begin
          probed = 1'b1;
          if (poll.probe_ack) begin
            wd.n_recoveries = wd.n_recoveries + 32'd1;
            wd.outage_last  = since_wedge;
            if (since_wedge > wd.outage_max) wd.outage_max = since_wedge;
            wd.in_episode = 1'b0;
            wd.wedge_time = '0;
            wd.reboot     = 1'b0;
            wd.rung       = '0;
            wd.mode       = M_HEALTHY;
          end else begin
            if (int'(wd.rung) + 1 < RUNG_STEPS) wd.rung = wd.rung + 2'd1;
            wd.mode     = M_BACKOFF;
            wd.deadline = now + BACKOFF_MS[wd.rung];
          end
        end
      end
      M_RSTLOW: begin
        // Releasing the reset line needs no bus access.
        if (due(now, wd.deadline)) begin
          wd.rst_low  = 1'b0;
          wd.mode     = M_RSTHIGH;
          wd.deadline = now + 32'(wd_cfg.reset_settle_ms);
        end
      end
      M_RSTHIGH: begin
        if (poll.may_probe && due(now, wd.deadline)) begin
          reinit      = 1'b1;
          wd.mode     = M_HARDBOOT;
          wd.deadline = now + 32'(wd_cfg.boot_hold_ms);
        end
      end
      default: begin
        if (poll.may_probe && due(now, wd.deadline)) begin
          if (int'(wd.rung) >= FIRST_HARD_STEP) begin
            wd.rst_low  = 1'b1;
            wd.mode     = M_RSTLOW;
            wd.deadline = now + 32'(wd_cfg.reset_low_ms);
          end else begin
            reinit      = 1'b1;
            wd.mode     = M_SOFTBOOT;
            wd.deadline = now + 32'(wd_cfg.boot_hold_ms);
          end
        end
      end
    endcase

    r.probe_issued       = probed;
    r.driver_reinit      = reinit;
    r.reset_held_low     = wd.rst_low;
    r.reboot_recommended = wd.reboot;
    r.watch_state        = wd.mode;
    r.ladder_rung        = wd.rung;
    r.last_outage_ms     = wd.outage_last;
    r.max_outage_ms      = wd.outage_max;
    r.wedge_count        = wd.n_wedges;
    r.recovery_count     = wd.n_recoveries;
    r.wake_count         = wd.n_wakes;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_fields++;
    end
  endtask

  // Sender: a new item goes out only once the previous one was taken.
  always @(negedge clk_i) begin : drive_polls
    item_t nxt;
    if (rst_ni && (!poll_if.valid || poll_taken)) begin
      if (poll_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = poll_backlog.pop_front();
        poll_if.valid     <= 1'b1;
        poll_if.now_ms    <= nxt.now_ms;
        poll_if.saw_touch <= nxt.saw_touch;
        poll_if.may_probe <= nxt.may_probe;
        poll_if.probe_ack <= nxt.probe_ack;
      end else begin
        poll_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs that fill the block up.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      result_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_wanted) begin
      result_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    item_t   taken;
    result_t want;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (report_fifo.size() == 0) begin
          $error("result item with no poll waiting for it");
          bad_fields++;
        end else begin
          want = report_fifo.pop_front();
          check_field("probe_issued", want.probe_issued, result_if.probe_issued);
          check_field("driver_reinit", want.driver_reinit, result_if.driver_reinit);
          check_field("reset_held_low", want.reset_held_low, result_if.reset_held_low);
          check_field("reboot_recommended", want.reboot_recommended,
                      result_if.reboot_recommended);
          check_field("watch_state", want.watch_state, result_if.watch_state);
          check_field("ladder_rung", want.ladder_rung, result_if.ladder_rung);
          check_field("last_outage_ms", want.last_outage_ms, result_if.last_outage_ms);
          check_field("max_outage_ms", want.max_outage_ms, result_if.max_outage_ms);
          check_field("wedge_count", want.wedge_count, result_if.wedge_count);
          check_field("recovery_count", want.recovery_count, result_if.recovery_count);
          check_field("wake_count", want.wake_count, result_if.wake_count);
        end
      end
      poll_taken = poll_if.valid && poll_if.ready;
      if (poll_taken) begin
        taken.now_ms    = poll_if.now_ms;
        taken.saw_touch = poll_if.saw_touch;
        taken.may_probe = poll_if.may_probe;
        taken.probe_ack = poll_if.probe_ack;
        report_fifo.push_back(advance_watchdog(taken));
      end
    end else begin
      poll_taken = 1'b0;
    end
  end

  task automatic push_poll(input bit [31:0] t, input bit touch, input bit bus, input bit ack);
    item_t it;
    it.now_ms    = t;
    it.saw_touch = touch;
    it.may_probe = bus;
    it.probe_ack = ack;
    poll_backlog.push_back(it);
  endtask

  // Random polls: time mostly creeps forward, with rare long jumps and wraps. The chip
  // answers in stretches that are mostly healthy, mostly dead or mixed, so the ladder
  // gets walked end to end instead of bouncing at its first rung.
  task automatic queue_polls(input int count);
    bit [31:0] step;
    int        r;
    for (int k = 0; k < count; k++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 5);
        r = $urandom_range(2);
        ack_good_pct = (r == 0) ? 8 : ((r == 1) ? 92 : 50);
      end
      seg_left--;
      r = $urandom_range(99);
      if (r < 70) step = $urandom_range(200);
      else if (r < 90) step = $urandom_range(3000, 200);
      else if (r < 98) step = $urandom_range(60000, 3000);
      else step = $urandom();
      stim_now = stim_now + step;
      if (stim_touch) stim_touch = ($urandom_range(99) < 65);
      else stim_touch = ($urandom_range(99) < 15);
      push_poll(stim_now, stim_touch, $urandom_range(99) < 88,
                $urandom_range(99) < ack_good_pct);
    end
  endtask

  task automatic set_reg(input cfg_idx_e idx, input bit [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PROBE_INTERVAL: wd_cfg.probe_interval_ms   = data;
      CFG_AWAKE_WINDOW:   wd_cfg.awake_span_ms       = data[15:0];
      CFG_SUSPECT_LIMIT:  wd_cfg.suspect_probe_limit = data[3:0];
      CFG_SUSPECT_SPACE:  wd_cfg.suspect_gap_ms      = data[15:0];
      CFG_BOOT_WAIT:      wd_cfg.boot_hold_ms        = data[15:0];
      CFG_RESET_LOW:      wd_cfg.reset_low_ms        = data[15:0];
      CFG_RESET_SETTLE:   wd_cfg.reset_settle_ms     = data[15:0];
      default:            wd_cfg.reboot_bound_ms     = data;
    endcase
  endtask

  task automatic apply_settings(input bit [31:0] probe, input bit [31:0] awake,
                                input bit [31:0] limit, input bit [31:0] spacing,
                                input bit [31:0] boot, input bit [31:0] low,
                                input bit [31:0] settle, input bit [31:0] reboot);
    set_reg(CFG_PROBE_INTERVAL, probe);
    set_reg(CFG_AWAKE_WINDOW, awake);
    set_reg(CFG_SUSPECT_LIMIT, limit);
    set_reg(CFG_SUSPECT_SPACE, spacing);
    set_reg(CFG_BOOT_WAIT, boot);
    set_reg(CFG_RESET_LOW, low);
    set_reg(CFG_RESET_SETTLE, settle);
    set_reg(CFG_REBOOT_AFTER, reboot);
  endtask

  // Waits until every poll was taken and every report came back.
  task automatic drain();
    while (!(poll_backlog.size() == 0 && !poll_if.valid && report_fifo.size() == 0))
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PROBE_INTERVAL;
    cfg_wdata_i = '0;
    poll_if.valid = 1'b0;
    poll_if.now_ms = '0;
    poll_if.saw_touch = 1'b0;
    poll_if.may_probe = 1'b0;
    poll_if.probe_ack = 1'b0;
    result_if.ready = 1'b0;
    bad_fields = 0;
    holds_wanted = 0;
    holds_served = 0;
    hold_left = 0;
    poll_taken = 1'b0;
    stim_now = '0;
    stim_touch = 1'b0;
    seg_left = 0;
    ack_good_pct = 92;
    send_idle_pct = 16;
    recv_stall_pct = 52;
    reset_watchdog();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Full walk: release probe into suspect, wedge, every ladder rung with the reset
    // line released while the bus is busy, recovery, a wake re-init and a wrap of time.
    push_poll(32'd0, 1'b0, 1'b1, 1'b1);
    push_poll(32'd0, 1'b1, 1'b1, 1'b1);
    push_poll(32'd100, 1'b0, 1'b0, 1'b1);
    push_poll(32'd200, 1'b0, 1'b1, 1'b0);
    push_poll(32'd300, 1'b0, 1'b1, 1'b0);
    push_poll(32'd350, 1'b0, 1'b1, 1'b0);
    push_poll(32'd500, 1'b0, 1'b1, 1'b0);
    push_poll(32'd5500, 1'b0, 1'b0, 1'b1);
    push_poll(32'd5500, 1'b0, 1'b1, 1'b1);
    push_poll(32'd5950, 1'b0, 1'b1, 1'b0);
    push_poll(32'd20950, 1'b0, 1'b1, 1'b1);
    push_poll(32'd21400, 1'b0, 1'b1, 1'b0);
    push_poll(32'd61400, 1'b0, 1'b1, 1'b1);
    push_poll(32'd61650, 1'b0, 1'b0, 1'b0);
    push_poll(32'd62300, 1'b0, 1'b1, 1'b1);
    push_poll(32'd62750, 1'b0, 1'b1, 1'b0);
    push_poll(32'd182750, 1'b1, 1'b1, 1'b1);
    push_poll(32'd183000, 1'b0, 1'b1, 1'b1);
    push_poll(32'd183650, 1'b0, 1'b1, 1'b1);
    push_poll(32'd184100, 1'b0, 1'b1, 1'b1);
    push_poll(32'd200000, 1'b0, 1'b1, 1'b0);
    push_poll(32'd200450, 1'b0, 1'b1, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    push_poll(32'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1, 1'b1, 1'b1, 1'b1);
    queue_polls(330);
    holds_wanted++;
    drain();

    // Short timings so that the ladder turns over many times.
    apply_settings(32'd500, 32'd400, 32'd2, 32'd20, 32'd30, 32'd10, 32'd20, 32'd20000);
    queue_polls(450);
    drain();

    send_idle_pct = 52;
    recv_stall_pct = 16;
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_polls(150);
    drain();
    apply_settings(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_polls(150);
    drain();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF, 32'hF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                   32'hFFFF, 32'hFFFF_FFFF);
    queue_polls(150);
    drain();
    // A period of exactly half the time range sits right on the edge of being due:
    // no poll sees it as due until half the range has passed since it was set.
    apply_settings(32'h8000_0000, 32'hFFFF, 32'hF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                   32'hFFFF, 32'h7FFF_FFFF);
    queue_polls(150);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) begin
      // Upper bits beyond a register's width must be dropped by the block.
      apply_settings($urandom_range(20000), {16'($urandom), 16'($urandom_range(2500))},
                     {28'($urandom), 4'($urandom_range(15))},
                     {16'($urandom), 16'($urandom_range(500))},
                     {16'($urandom), 16'($urandom_range(1000))},
                     {16'($urandom), 16'($urandom_range(600))},
                     {16'($urandom), 16'($urandom_range(1500))},
                     $urandom_range(200000));
      queue_polls(180);
      holds_wanted++;
      drain();
    end

    if (bad_fields == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tcrw_pkg.sv
hdl/tcrw_if.sv
hdl/tcrw_cfg.sv
hdl/tcrw_step.sv
hdl/touch_controller_recovery_watchdog.sv
hdl/tcrw_checker.sv
bench/tb_top.sv
